### rtl/websocket_frame_deframer_unit_assert.svh
// Assertion macros for the WebSocket frame deframer checker.
// Depends on nothing; included by the checker file.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// Checked only while reset is released.
`define WSFD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wsfd assertion failed");

// Checked on every edge, reset included.
`define WSFD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wsfd assertion failed");

`endif

### rtl/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// Depends on nothing.
package wsfd_pkg;

  localparam logic [7:0] MASK_BIT      = 8'h80;
  localparam logic [6:0] LEN_CODE_MASK = 7'h7F;
  localparam logic [6:0] LEN_CODE_16   = 7'd126;
  localparam logic [6:0] LEN_CODE_64   = 7'd127;
  localparam logic [2:0] EXT16_COUNT   = 3'd1;
  localparam logic [2:0] EXT64_COUNT   = 3'd7;
  localparam logic [2:0] KEY_COUNT     = 3'd3;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DISCARD = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_byte;
    logic       message_end;
    logic       frame_status;
  } out_beat_t;

endpackage

### rtl/wsfd_if.sv
// Valid/ready channel interfaces for the deframer's input and result beats.
// Depends on nothing.
interface wsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_buffer;

  modport source (output valid, output in_byte, output end_of_buffer, input ready);
  modport sink (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

interface wsfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       has_byte;
  logic       message_end;
  logic       frame_status;

  modport source (output valid, output payload_byte, output has_byte,
                  output message_end, output frame_status, input ready);
  modport sink (input valid, input payload_byte, input has_byte,
                input message_end, input frame_status, output ready);
endinterface

### rtl/wsfd_in_reg.sv
// Input register stage holding one received beat until the parser takes it.
// Depends on wsfd_pkg.
module wsfd_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wsfd_pkg::in_beat_t in_beat,
  input  logic              take,
  output logic              beat_valid,
  output wsfd_pkg::in_beat_t beat
);
  import wsfd_pkg::*;

  logic     valid_r, valid_nxt;
  in_beat_t beat_r;
  logic     load;

  assign in_ready = rst_n && (!valid_r || take);
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= in_beat;
    end
  end

  assign beat_valid = valid_r;
  assign beat       = beat_r;
endmodule

### rtl/wsfd_parser.sv
// Frame header parser and payload unmasking; one beat per step.
// Depends on wsfd_pkg.
module wsfd_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  wsfd_pkg::in_beat_t beat,
  output logic               res_valid,
  output wsfd_pkg::out_beat_t res
);
  import wsfd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  count_r, count_nxt;
  logic        mask_flag_r, mask_flag_nxt;
  logic [31:0] mask_key_r, mask_key_nxt;
  logic [63:0] remaining_r, remaining_nxt;
  logic [1:0]  mask_pos_r, mask_pos_nxt;

  logic [7:0]  b;
  logic [6:0]  code;
  logic [63:0] ext_len;
  logic [7:0]  key_byte;
  logic        bare, data, last;
  logic [7:0]  value;

  assign b       = beat.in_byte;
  assign code    = b[6:0] & LEN_CODE_MASK;
  assign ext_len = {remaining_r[55:0], b};

  always_comb begin
    unique case (mask_pos_r)
      2'd0:    key_byte = mask_key_r[31:24];
      2'd1:    key_byte = mask_key_r[23:16];
      2'd2:    key_byte = mask_key_r[15:8];
      default: key_byte = mask_key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    mask_flag_nxt = mask_flag_r;
    mask_key_nxt  = mask_key_r;
    remaining_nxt = remaining_r;
    mask_pos_nxt  = mask_pos_r;
    bare          = 1'b0;
    data          = 1'b0;
    last          = 1'b0;
    value         = 8'd0;
    unique case (phase_r)
      PH_FIRST: begin
        phase_nxt = PH_LENGTH;
      end
      PH_LENGTH: begin
        mask_flag_nxt = (b & MASK_BIT) != 8'd0;
        mask_pos_nxt  = 2'd0;
        if (code == LEN_CODE_16) begin
          remaining_nxt = 64'd0;
          count_nxt     = EXT16_COUNT;
          phase_nxt     = PH_EXTLEN;
        end else if (code == LEN_CODE_64) begin
          remaining_nxt = 64'd0;
          count_nxt     = EXT64_COUNT;
          phase_nxt     = PH_EXTLEN;
        end else begin
          remaining_nxt = {57'd0, code};
          if (mask_flag_nxt) begin
            phase_nxt = PH_KEY;
            count_nxt = KEY_COUNT;
          end else if (code == 7'd0) begin
            phase_nxt = PH_DISCARD;
            bare      = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_EXTLEN: begin
        remaining_nxt = ext_len;
        if (count_r == 3'd0) begin
          if (mask_flag_r) begin
            phase_nxt = PH_KEY;
            count_nxt = KEY_COUNT;
          end else if (ext_len == 64'd0) begin
            phase_nxt = PH_DISCARD;
            bare      = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end else begin
          count_nxt = count_r - 3'd1;
        end
      end
      PH_KEY: begin
        mask_key_nxt = {mask_key_r[23:0], b};
        if (count_r == 3'd0) begin
          if (remaining_r == 64'd0) begin
            phase_nxt = PH_DISCARD;
            bare      = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end else begin
          count_nxt = count_r - 3'd1;
        end
      end
      PH_PAYLOAD: begin
        value         = mask_flag_r ? (b ^ key_byte) : b;
        mask_pos_nxt  = mask_pos_r + 2'd1;
        remaining_nxt = remaining_r - 64'd1;
        data          = 1'b1;
        if (remaining_r == 64'd1) begin
          last      = 1'b1;
          phase_nxt = PH_DISCARD;
        end
      end
      default: begin
        phase_nxt = PH_DISCARD;
      end
    endcase

    res_valid = 1'b0;
    res       = '0;
    if (step) begin
      priority if (beat.end_of_buffer && phase_nxt != PH_DISCARD) begin
        res_valid        = 1'b1;
        res.message_end  = 1'b1;
        res.frame_status = 1'b1;
      end else if (data) begin
        res_valid        = 1'b1;
        res.payload_byte = value;
        res.has_byte     = 1'b1;
        res.message_end  = last;
      end else if (bare) begin
        res_valid       = 1'b1;
        res.message_end = 1'b1;
      end
    end
    if (beat.end_of_buffer) begin
      phase_nxt = PH_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      count_r     <= 3'd0;
      mask_flag_r <= 1'b0;
      mask_pos_r  <= 2'd0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      mask_flag_r <= mask_flag_nxt;
      mask_pos_r  <= mask_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      mask_key_r  <= mask_key_nxt;
      remaining_r <= remaining_nxt;
    end
  end
endmodule

### rtl/wsfd_out_reg.sv
// Result register holding one beat until the downstream side takes it.
// Depends on wsfd_pkg.
module wsfd_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  wsfd_pkg::out_beat_t res,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output wsfd_pkg::out_beat_t out_beat
);
  import wsfd_pkg::*;

  logic      valid_r, valid_nxt;
  out_beat_t beat_r;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;
endmodule

### rtl/websocket_frame_deframer_unit.sv
// WebSocket frame deframer: one received byte per beat, unmasked payload out.
// Path: input register, then the parser, then the result register.
// Throughput: one byte per cycle while the result register is free; the input
// and result registers each move a beat per cycle, even for a byte with no result.
// Reset (rst_n low, synchronous): both registers empty, parser waits for a header.
module websocket_frame_deframer_unit (
  input logic        clk,
  input logic        rst_n,
  wsfd_in_if.sink    in_bus,
  wsfd_out_if.source out_bus
);
  import wsfd_pkg::*;

  in_beat_t  in_beat;
  in_beat_t  beat;
  out_beat_t res;
  out_beat_t out_beat;
  logic      beat_valid;
  logic      free;
  logic      step;
  logic      res_valid;

  assign in_beat.in_byte       = in_bus.in_byte;
  assign in_beat.end_of_buffer = in_bus.end_of_buffer;
  assign step                  = beat_valid && free;

  wsfd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_ready   (in_bus.ready),
    .in_beat    (in_beat),
    .take       (step),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  wsfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .beat      (beat),
    .res_valid (res_valid),
    .res       (res)
  );

  wsfd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .free      (free),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_beat  (out_beat)
  );

  assign out_bus.payload_byte = out_beat.payload_byte;
  assign out_bus.has_byte     = out_beat.has_byte;
  assign out_bus.message_end  = out_beat.message_end;
  assign out_bus.frame_status = out_beat.frame_status;
endmodule

### rtl/wsfd_checker.sv
// Port-level checks of the deframer's result channel, bound to the top level.
// Depends on websocket_frame_deframer_unit_assert.svh and the top level.
`include "websocket_frame_deframer_unit_assert.svh"

module wsfd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] payload_byte,
  input logic       has_byte,
  input logic       message_end,
  input logic       frame_status
);
  logic [10:0] beat_bits;

  assign beat_bits = {payload_byte, has_byte, message_end, frame_status};

  `WSFD_ASSERT_ALWAYS(a_empty_after_reset, !rst_n |=> !out_valid)
  `WSFD_ASSERT(a_hold_while_stalled, out_valid && !out_ready |=> out_valid && $stable(beat_bits))
  `WSFD_ASSERT(a_marker_carries_no_data, out_valid && !has_byte |-> payload_byte == 8'd0 && message_end)
  `WSFD_ASSERT(a_truncation_is_bare_end, out_valid && frame_status |-> !has_byte && message_end)
endmodule

bind websocket_frame_deframer_unit wsfd_checker u_wsfd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .payload_byte (out_bus.payload_byte),
  .has_byte     (out_bus.has_byte),
  .message_end  (out_bus.message_end),
  .frame_status (out_bus.frame_status)
);

### dv/tb.sv
// Testbench for websocket_frame_deframer_unit: header, length, key and payload
// parsing checked beat by beat against an in-bench parser model or fixed beats.
// Depends on wsfd_pkg, the wsfd_in_if / wsfd_out_if interfaces and the unit itself.
`timescale 1ns / 100ps

module tb;
  import wsfd_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int unsigned HOLD_AT      = 600;
  localparam int unsigned DRAIN_AT     = 1200;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned SETTLE       = 20;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_BEAT} chk_t;
  typedef enum logic [1:0] {PACE_FULL, PACE_COIN, PACE_QUARTER, PACE_MOSTLY} pace_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       eob;
    chk_t       chk;
    out_beat_t  exp;
  } stim_row_t;

  localparam out_beat_t NO_BEAT    = '{8'h00, 1'b0, 1'b0, 1'b0};
  localparam out_beat_t TRUNC_MARK = '{8'h00, 1'b0, 1'b1, 1'b1};
  localparam out_beat_t EMPTY_MARK = '{8'h00, 1'b0, 1'b1, 1'b0};
  localparam out_beat_t LAST_FF    = '{8'hFF, 1'b1, 1'b1, 1'b0};

  localparam stim_row_t DIRECTED [25] = '{
    '{8'h81, 1'b1, CHK_BEAT,  TRUNC_MARK},
    '{8'h82, 1'b0, CHK_NONE,  NO_BEAT},
    '{8'h00, 1'b1, CHK_BEAT,  EMPTY_MARK},
    '{8'h00, 1'b0, CHK_NONE,  NO_BEAT},
    '{8'h82, 1'b0, CHK_NONE,  NO_BEAT},
    '{8'hFF, 1'b0, CHK_NONE,  NO_BEAT},
    '{8'h00, 1'b0, CHK_NONE,  NO_BEAT},
    '{8'hA5, 1'b0, CHK_NONE,  NO_BEAT},
    '{8'h5A, 1'b0, CHK_NONE,  NO_BEAT},
    '{8'hFF, 1'b0, CHK_MODEL, NO_BEAT},
    '{8'h00, 1'b1, CHK_MODEL, NO_BEAT},
    '{8'hFF, 1'b0, CHK_NONE,  NO_BEAT},
    '{8'h7E, 1'b0, CHK_NONE,  NO_BEAT},
    '{8'h00, 1'b1, CHK_BEAT,  TRUNC_MARK},
    '{8'h01, 1'b0, CHK_NONE,  NO_BEAT},
    '{8'h7F, 1'b0, CHK_NONE,  NO_BEAT},
    '{8'h00, 1'b0, CHK_NONE,  NO_BEAT},
    '{8'h00, 1'b0, CHK_NONE,  NO_BEAT},
    '{8'h00, 1'b0, CHK_NONE,  NO_BEAT},
    '{8'h00, 1'b0, CHK_NONE,  NO_BEAT},
    '{8'h00, 1'b0, CHK_NONE,  NO_BEAT},
    '{8'h00, 1'b0, CHK_NONE,  NO_BEAT},
    '{8'h00, 1'b0, CHK_NONE,  NO_BEAT},
    '{8'h01, 1'b0, CHK_NONE,  NO_BEAT},
    '{8'hFF, 1'b1, CHK_BEAT,  LAST_FF}
  };

  logic clk;
  logic rst_n;

  wsfd_in_if  in_ch ();
  wsfd_out_if out_ch ();

  websocket_frame_deframer_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  phase_t      rx_phase;
  logic [2:0]  hdr_left;
  logic        masked;
  logic [31:0] key_word;
  logic [63:0] remaining;
  logic [1:0]  key_idx;

  out_beat_t   expected_beats [$];
  out_beat_t   want;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  bit          hold_req = 1'b0;
  pace_t       pace = PACE_FULL;
  int unsigned pace_left = 0;
  logic [1:0]  pace_tick = 2'd0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void reset_parser();
    rx_phase  = PH_FIRST;
    hdr_left  = 3'd0;
    masked    = 1'b0;
    key_word  = 32'd0;
    remaining = 64'd0;
    key_idx   = 2'd0;
  endfunction

  function automatic bit length_done();
    if (masked) begin
      rx_phase = PH_KEY;
      hdr_left = KEY_COUNT;
      return 1'b0;
    end
    if (remaining == 64'd0) begin
      rx_phase = PH_DISCARD;
      return 1'b1;
    end
    rx_phase = PH_PAYLOAD;
    return 1'b0;
  endfunction

  function automatic bit parse_rx_byte(input logic [7:0] b, input logic eob,
                                       output out_beat_t r);
    logic [6:0] code;
    logic [7:0] k;
    logic [7:0] value;
    bit         bare;
    bit         data;
    bit         last;
    bit         got;
    bare  = 1'b0;
    data  = 1'b0;
    last  = 1'b0;
    value = 8'h00;
    case (rx_phase)
      PH_FIRST: rx_phase = PH_LENGTH;
      PH_LENGTH: begin
        code      = b[6:0] & LEN_CODE_MASK;
        masked    = (b & MASK_BIT) != 8'h00;
        key_idx   = 2'd0;
        remaining = 64'd0;
        if (code == LEN_CODE_16) begin
          hdr_left = EXT16_COUNT;
          rx_phase = PH_EXTLEN;
        end else if (code == LEN_CODE_64) begin
          hdr_left = EXT64_COUNT;
          rx_phase = PH_EXTLEN;
        end else begin
          remaining = 64'(code);
          bare = length_done();
        end
      end
      PH_EXTLEN: begin
        remaining = {remaining[55:0], b};
        if (hdr_left == 3'd0) bare = length_done();
        else hdr_left = hdr_left - 3'd1;
      end
      PH_KEY: begin
        key_word = {key_word[23:0], b};
        if (hdr_left == 3'd0) begin
          if (remaining == 64'd0) begin
            rx_phase = PH_DISCARD;
            bare = 1'b1;
          end else begin
            rx_phase = PH_PAYLOAD;
          end
        end else begin
          hdr_left = hdr_left - 3'd1;
        end
      end
      PH_PAYLOAD: begin
        k = masked ? 8'(key_word >> (5'd24 - {key_idx, 3'b000})) : 8'h00;
        value     = b ^ k;
        key_idx   = key_idx + 2'd1;
        remaining = remaining - 64'd1;
        data      = 1'b1;
        if (remaining == 64'd0) begin
          last     = 1'b1;
          rx_phase = PH_DISCARD;
        end
      end
      default: rx_phase = PH_DISCARD;
    endcase
    r   = NO_BEAT;
    got = 1'b1;
    if (eob && rx_phase != PH_DISCARD) begin
      r = TRUNC_MARK;
    end else if (data) begin
      r.payload_byte = value;
      r.has_byte     = 1'b1;
      r.message_end  = last;
    end else if (bare) begin
      r = EMPTY_MARK;
    end else begin
      got = 1'b0;
    end
    if (eob) reset_parser();
    return got;
  endfunction

  task automatic offer_beat(input stim_row_t row);
    out_beat_t r;
    bit        got;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    in_ch.valid         <= 1'b1;
    in_ch.in_byte       <= row.in_byte;
    in_ch.end_of_buffer <= row.eob;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    got = parse_rx_byte(row.in_byte, row.eob, r);
    case (row.chk)
      CHK_MODEL: if (got) expected_beats = {expected_beats, r};
      CHK_BEAT:  expected_beats = {expected_beats, row.exp};
      default:   ;
    endcase
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (expected_beats.size() == 0);
    @(posedge clk);
  endtask

  // Mostly well-formed frames with random content; a few are noise or cut short.
  task automatic send_random_buffer(output int unsigned counted);
    logic [7:0]  bytes [$];
    logic [63:0] len;
    logic [6:0]  code;
    int unsigned pick;
    int unsigned body;
    int unsigned cut;
    bit          masked_sel;
    bit          broken;
    stim_row_t   row;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      repeat ($urandom_range(1, 10)) bytes = {bytes, 8'($urandom)};
      broken = 1'b1;
    end else begin
      masked_sel = 1'($urandom_range(0, 1));
      bytes = {bytes, 8'($urandom)};
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        code = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 125))
                                           : 7'($urandom_range(0, 8));
        len = 64'(code);
        bytes = {bytes, {masked_sel, code}};
      end else if (pick < 8) begin
        len = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(0, 65535))
                                          : 64'($urandom_range(0, 40));
        bytes = {bytes, {masked_sel, LEN_CODE_16}};
        bytes = {bytes, len[15:8]};
        bytes = {bytes, len[7:0]};
      end else begin
        len = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                          : 64'($urandom_range(0, 40));
        bytes = {bytes, {masked_sel, LEN_CODE_64}};
        for (int i = 7; i >= 0; i--) bytes = {bytes, len[8*i +: 8]};
      end
      if (masked_sel) repeat (4) bytes = {bytes, 8'($urandom)};
      body = (len > 64'd300) ? $urandom_range(0, 300) : int'(len);
      repeat (body) bytes = {bytes, 8'($urandom)};
      broken = (len > 64'd300) || ($urandom_range(0, 7) == 0);
    end
    if (broken) begin
      cut = $urandom_range(1, bytes.size());
      while (bytes.size() > cut) bytes.delete(bytes.size() - 1);
    end
    counted = bytes.size();
    if (!broken) repeat ($urandom_range(0, 3)) bytes = {bytes, 8'($urandom)};
    foreach (bytes[i]) begin
      row = '{bytes[i], i == bytes.size() - 1, CHK_MODEL, NO_BEAT};
      offer_beat(row);
    end
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (pace_left == 0) begin
          pace      = pace_t'($urandom_range(0, 3));
          pace_left = $urandom_range(20, 200);
        end
        pace_left--;
        pace_tick = pace_tick + 2'd1;
        case (pace)
          PACE_FULL:    out_ch.ready <= 1'b1;
          PACE_COIN:    out_ch.ready <= 1'($urandom_range(0, 1));
          PACE_QUARTER: out_ch.ready <= (pace_tick == 2'd0);
          default:      out_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: payload_byte %0h has_byte %0b",
               out_ch.payload_byte, out_ch.has_byte);
        mismatch_count++;
      end else begin
        want = expected_beats.pop_front();
        if (out_ch.payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %0h, got %0h", want.payload_byte,
                 out_ch.payload_byte);
          mismatch_count++;
        end
        if (out_ch.has_byte !== want.has_byte) begin
          $error("has_byte: expected %0b, got %0b", want.has_byte, out_ch.has_byte);
          mismatch_count++;
        end
        if (out_ch.message_end !== want.message_end) begin
          $error("message_end: expected %0b, got %0b", want.message_end,
                 out_ch.message_end);
          mismatch_count++;
        end
        if (out_ch.frame_status !== want.frame_status) begin
          $error("frame_status: expected %0b, got %0b", want.frame_status,
                 out_ch.frame_status);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned items_sent;
    int unsigned n;
    bit          hold_done;
    bit          drain_done;
    items_sent = 0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    reset_parser();
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.in_byte       <= 8'h00;
    in_ch.end_of_buffer <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED[i]) offer_beat(DIRECTED[i]);
    wait_for_results();
    while (items_sent < RANDOM_ITEMS) begin
      send_random_buffer(n);
      items_sent += n;
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && items_sent >= DRAIN_AT) begin
        wait_for_results();
        drain_done = 1'b1;
      end
    end
    wait_for_results();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
